[rtl/tsg_pkg.sv]
`default_nettype none

package tsg_pkg;

  localparam int CW  = 32;   // coordinate width
  localparam int FB  = 16;   // fraction bits of the coordinates
  localparam int EW  = CW + 1;          // edge and offset vectors
  localparam int PW  = 2 * EW;          // signed cross product terms
  localparam int SQW = 2 * CW;          // one squared edge component
  localparam int D2W = SQW + 2;         // squared edge length
  localparam int CRW = PW;              // cross product component, signed
  localparam int CMW = CRW - 1;         // its magnitude
  localparam int LOW = EW;              // low slice of the magnitude
  localparam int HIW = CMW - LOW;       // high slice of the magnitude
  localparam int CQW = 2 * CMW;         // squared component
  localparam int SW  = CQW + 2;         // sum of squared components
  localparam int DW  = CMW + EW + 2;    // orientation dot product, signed
  localparam int QW  = 63;              // normal quotient bits
  localparam int NRW = (QW + 1) / 2;    // normal root bits
  localparam int ARW = (SW - 2 * FB) / 2;  // area root bits
  localparam int ERW = (D2W + 2) / 2;   // edge root bits
  localparam int MXW = CW + 3;          // offset vertex sum
  localparam int MHW = MXW - 18;        // high slice of the vertex sum
  localparam int MYW = 19;              // folded vertex sum
  localparam int MQW = 18;              // folded quotient

  localparam logic [MXW-1:0] MID_OFF = MXW'(64'd3 << CW);
  localparam logic [16:0]    MID_K   = 17'd87381;   // (2^18 - 1) / 3
  localparam logic [19:0]    MID_M   = 20'd699050;  // floor(2^21 / 3)

  localparam int PRE = 6;
  localparam int LAT = PRE + QW + NRW + 1;
  localparam int ADLY = QW + NRW - ARW;
  localparam int EDLY = PRE + QW + NRW - 3 - ERW;
  localparam int LDLY = QW + NRW;

  typedef struct packed {
    logic [2:0][CW-1:0] mid;
    logic               deg;
    logic               flip;
    logic [2:0]         csgn;
  } tsg_late_t;

endpackage

`default_nettype wire

[rtl/tsg_isqrt.sv]
`default_nettype none

module tsg_isqrt #(
  parameter int RW = tsg_pkg::NRW
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*RW-1:0] rad,
  output logic      [RW-1:0]   root
);

  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [RW+3:0]   acc;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;
    logic [RW+1:0]   rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    assign acc      = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial    = {2'b00, root_in, 2'b01};
    assign diff     = acc - trial;
    assign ge       = (acc >= trial);
    assign rem_nxt  = ge ? diff[RW+1:0] : acc[RW+1:0];
    assign root_nxt = {root_in[RW-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= {rad_in[2*RW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

`default_nettype wire

[rtl/triangle_side_geometry.sv]
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    three vertices and owner centroid
// out      output     out_valid / out_ready  area, normal, centroid, edge, flag
//
// The datapath is a fixed pipeline of 102 stages and accepts one item per cycle
// unless the output stalls. Its depth is set by the 63-step restoring divider for
// the normal followed by the 32-step square root, both with one step per stage.
// Reset clears only the stage valid bits.
// A stalled output holds the whole pipeline, so no item is dropped or repeated.

module triangle_side_geometry (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [31:0]   in_p0_x,
  input  wire logic signed [31:0]   in_p0_y,
  input  wire logic signed [31:0]   in_p0_z,
  input  wire logic signed [31:0]   in_p1_x,
  input  wire logic signed [31:0]   in_p1_y,
  input  wire logic signed [31:0]   in_p1_z,
  input  wire logic signed [31:0]   in_p2_x,
  input  wire logic signed [31:0]   in_p2_y,
  input  wire logic signed [31:0]   in_p2_z,
  input  wire logic signed [31:0]   in_owner_cx,
  input  wire logic signed [31:0]   in_owner_cy,
  input  wire logic signed [31:0]   in_owner_cz,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic             [51:0]   out_area,
  output logic signed      [31:0]   out_normal_x,
  output logic signed      [31:0]   out_normal_y,
  output logic signed      [31:0]   out_normal_z,
  output logic signed      [31:0]   out_mid_x,
  output logic signed      [31:0]   out_mid_y,
  output logic signed      [31:0]   out_mid_z,
  output logic             [33:0]   out_longest_edge,
  output logic                      out_degenerate
);

  localparam int CW  = tsg_pkg::CW;
  localparam int EW  = tsg_pkg::EW;
  localparam int PW  = tsg_pkg::PW;
  localparam int SQW = tsg_pkg::SQW;
  localparam int D2W = tsg_pkg::D2W;
  localparam int CRW = tsg_pkg::CRW;
  localparam int CMW = tsg_pkg::CMW;
  localparam int LOW = tsg_pkg::LOW;
  localparam int HIW = tsg_pkg::HIW;
  localparam int CQW = tsg_pkg::CQW;
  localparam int SW  = tsg_pkg::SW;
  localparam int DW  = tsg_pkg::DW;
  localparam int QW  = tsg_pkg::QW;
  localparam int NRW = tsg_pkg::NRW;
  localparam int ARW = tsg_pkg::ARW;
  localparam int ERW = tsg_pkg::ERW;
  localparam int MXW = tsg_pkg::MXW;
  localparam int MHW = tsg_pkg::MHW;
  localparam int MYW = tsg_pkg::MYW;
  localparam int MQW = tsg_pkg::MQW;
  localparam int LAT = tsg_pkg::LAT;
  localparam int ADLY = tsg_pkg::ADLY;
  localparam int EDLY = tsg_pkg::EDLY;
  localparam int LDLY = tsg_pkg::LDLY;
  localparam int FB2 = 2 * tsg_pkg::FB;

  logic adv;
  logic [LAT-1:0] vld_r;

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv && rst_n;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  logic signed [CW-1:0] p0 [3];
  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];
  logic signed [CW-1:0] own [3];

  assign p0  = '{in_p0_x, in_p0_y, in_p0_z};
  assign p1  = '{in_p1_x, in_p1_y, in_p1_z};
  assign p2  = '{in_p2_x, in_p2_y, in_p2_z};
  assign own = '{in_owner_cx, in_owner_cy, in_owner_cz};

  // Stage 1: edge vectors and the folded vertex sum.
  logic signed [EW-1:0]  e1_r [3];
  logic signed [EW-1:0]  e2_r [3];
  logic signed [EW-1:0]  ed_r [3];
  logic signed [EW-1:0]  dv1_r [3];
  logic        [MHW-1:0] xh_r [3];
  logic        [MYW-1:0] y1_r [3];
  logic signed [MXW-1:0] tsum [3];
  logic        [MXW-1:0] mx [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tsum[j] = MXW'(p0[j]) + MXW'(p1[j]) + MXW'(p2[j]) + MXW'(1);
      mx[j]   = tsum[j] + tsg_pkg::MID_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        e1_r[j]  <= EW'(p1[j]) - EW'(p0[j]);
        e2_r[j]  <= EW'(p2[j]) - EW'(p0[j]);
        ed_r[j]  <= EW'(p1[j]) - EW'(p2[j]);
        dv1_r[j] <= EW'(own[j]) - EW'(p0[j]);
        xh_r[j]  <= mx[j][MXW-1:18];
        y1_r[j]  <= MYW'(mx[j][MXW-1:18]) + MYW'(mx[j][17:0]);
      end
    end
  end

  // Stage 2: cross product terms, squared edges and the division by three.
  logic signed [PW-1:0]  cpa_r [3];
  logic signed [PW-1:0]  cpb_r [3];
  logic        [SQW-1:0] sq_r [3][3];
  logic signed [EW-1:0]  dv2_r [3];
  logic        [33:0]    pm_r [3];
  logic        [MQW-1:0] qy0_r [3];
  logic        [MYW-1:0] y2_r [3];
  logic        [38:0]    yprod [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      yprod[j] = 39'(y1_r[j]) * 39'(tsg_pkg::MID_M);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        cpa_r[j]    <= e1_r[(j + 1) % 3] * e2_r[(j + 2) % 3];
        cpb_r[j]    <= e1_r[(j + 2) % 3] * e2_r[(j + 1) % 3];
        sq_r[0][j]  <= e1_r[j] * e1_r[j];
        sq_r[1][j]  <= e2_r[j] * e2_r[j];
        sq_r[2][j]  <= ed_r[j] * ed_r[j];
        dv2_r[j]    <= dv1_r[j];
        pm_r[j]     <= 34'(xh_r[j]) * 34'(tsg_pkg::MID_K);
        qy0_r[j]    <= yprod[j][38:21];
        y2_r[j]     <= y1_r[j];
      end
    end
  end

  // Stage 3: cross product, squared edge lengths and the vertex centroid.
  logic signed [CRW-1:0] c_r [3];
  logic        [D2W-1:0] d2_r [3];
  logic signed [EW-1:0]  dv3_r [3];
  logic        [CW-1:0]  mid3_r [3];
  logic        [MYW:0]   mrem [3];
  logic        [MQW-1:0] qy [3];
  logic        [33:0]    msum [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mrem[j] = (MYW+1)'(y2_r[j]) - (MYW+1)'({qy0_r[j], 1'b0}) - (MYW+1)'(qy0_r[j]);
      qy[j]   = qy0_r[j] + MQW'(mrem[j] >= (MYW+1)'(3));
      msum[j] = pm_r[j] + 34'(qy[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        c_r[j]    <= cpa_r[j] - cpb_r[j];
        d2_r[j]   <= D2W'(sq_r[j][0]) + D2W'(sq_r[j][1]) + D2W'(sq_r[j][2]);
        dv3_r[j]  <= dv2_r[j];
        mid3_r[j] <= msum[j][CW-1:0];
      end
    end
  end

  // Stage 4: partial products of the squared magnitude and of the dot product.
  logic        [2*LOW-1:0]     sll_r [3];
  logic        [LOW+HIW-1:0]   slh_r [3];
  logic        [2*HIW-1:0]     shh_r [3];
  logic signed [2*EW-1:0]      dh_r [3];
  logic signed [2*EW:0]        dl_r [3];
  logic        [2:0]           csgn4_r;
  logic        [CW-1:0]        mid4_r [3];
  logic        [CRW-1:0]       cabs [3];
  logic signed [EW-1:0]       chi [3];
  logic signed [LOW:0]         clo [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cabs[j] = c_r[j][CRW-1] ? CRW'(-c_r[j]) : CRW'(c_r[j]);
      chi[j]  = c_r[j][CRW-1:LOW];
      clo[j]  = {1'b0, c_r[j][LOW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        sll_r[j]   <= cabs[j][LOW-1:0] * cabs[j][LOW-1:0];
        slh_r[j]   <= cabs[j][LOW-1:0] * cabs[j][CMW-1:LOW];
        shh_r[j]   <= cabs[j][CMW-1:LOW] * cabs[j][CMW-1:LOW];
        dh_r[j]    <= chi[j] * dv3_r[j];
        dl_r[j]    <= clo[j] * dv3_r[j];
        csgn4_r[j] <= c_r[j][CRW-1];
        mid4_r[j]  <= mid3_r[j];
      end
    end
  end

  // Stage 5: squared components and dot product terms.
  logic        [CQW-1:0] csq5_r [3];
  logic signed [DW-1:0]  dtm_r [3];
  logic        [2:0]     csgn5_r;
  logic        [CW-1:0]  mid5_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        csq5_r[j] <= (CQW'(shh_r[j]) << (2 * LOW)) + (CQW'(slh_r[j]) << (LOW + 1))
                     + CQW'(sll_r[j]);
        dtm_r[j]  <= (DW'(dh_r[j]) <<< LOW) + DW'(dl_r[j]);
        mid5_r[j] <= mid4_r[j];
      end
      csgn5_r <= csgn4_r;
    end
  end

  // Stage 6: squared cross product length and orientation.
  logic        [SW-1:0]  s_r;
  logic signed [DW-1:0]  dot_r;
  logic        [CQW-1:0] csq6_r [3];
  logic        [2:0]     csgn6_r;
  logic        [CW-1:0]  mid6_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r     <= SW'(csq5_r[0]) + SW'(csq5_r[1]) + SW'(csq5_r[2]);
      dot_r   <= dtm_r[0] + dtm_r[1] + dtm_r[2];
      csq6_r  <= csq5_r;
      csgn6_r <= csgn5_r;
      mid6_r  <= mid5_r;
    end
  end

  // Normal quotients, one bit per stage.
  logic [SW-1:0] ds_r [QW];
  logic [SW-1:0] dr_r [3][QW];
  logic [QW-1:0] dq_r [3][QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [SW-1:0] s_in;

    if (k == 0) begin : g_s_first
      assign s_in = s_r;
    end else begin : g_s_next
      assign s_in = ds_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ds_r[k] <= s_in;
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [SW:0]   r_in;
      logic [SW:0]   r_sub;
      logic [QW-1:0] q_in;
      logic          ge;

      if (k == 0) begin : g_first
        assign r_in = (SW+1)'(csq6_r[j]);
        assign q_in = '0;
      end else begin : g_next
        assign r_in = {dr_r[j][k-1], 1'b0};
        assign q_in = dq_r[j][k-1];
      end

      assign r_sub = r_in - {1'b0, s_in};
      assign ge    = (r_in >= {1'b0, s_in});

      always_ff @(posedge clk) begin
        if (adv) begin
          dr_r[j][k] <= ge ? r_sub[SW-1:0] : r_in[SW-1:0];
          dq_r[j][k] <= {q_in[QW-2:0], ge};
        end
      end
    end
  end

  logic [NRW-1:0] nroot [3];

  for (genvar j = 0; j < 3; j++) begin : g_nsqrt
    tsg_isqrt #(.RW(NRW)) u_nsqrt (
      .clk  (clk),
      .en   (adv),
      .rad  ({1'b0, dq_r[j][QW-1]}),
      .root (nroot[j])
    );
  end

  // Area root and its alignment.
  logic [ARW-1:0] aroot;
  logic [ARW:0]   around;
  logic [ARW-1:0] adl_r [ADLY];

  tsg_isqrt #(.RW(ARW)) u_asqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (s_r[SW-1:FB2]),
    .root (aroot)
  );

  assign around = {1'b0, aroot} + (ARW+1)'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      adl_r[0] <= around[ARW:1];
      for (int k = 1; k < ADLY; k++) begin
        adl_r[k] <= adl_r[k-1];
      end
    end
  end

  // Edge lengths and their alignment.
  logic [ERW-1:0] eroot [3];
  logic [ERW:0]   eround [3];
  logic [ERW-1:0] elen [3];
  logic [ERW-1:0] ebest;
  logic [ERW-1:0] edl_r [EDLY];

  for (genvar j = 0; j < 3; j++) begin : g_esqrt
    tsg_isqrt #(.RW(ERW)) u_esqrt (
      .clk  (clk),
      .en   (adv),
      .rad  ({d2_r[j], 2'b00}),
      .root (eroot[j])
    );
    assign eround[j] = {1'b0, eroot[j]} + (ERW+1)'(1);
    assign elen[j]   = eround[j][ERW:1];
  end

  always_comb begin
    ebest = elen[0];
    for (int j = 1; j < 3; j++) begin
      if (elen[j] > ebest) begin
        ebest = elen[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      edl_r[0] <= ebest;
      for (int k = 1; k < EDLY; k++) begin
        edl_r[k] <= edl_r[k-1];
      end
    end
  end

  // Centroid, flags and component signs, aligned to the normal roots.
  tsg_pkg::tsg_late_t late_nxt;
  tsg_pkg::tsg_late_t ldl_r [LDLY];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      late_nxt.mid[j] = mid6_r[j];
    end
    late_nxt.deg  = (s_r == '0);
    late_nxt.flip = !dot_r[DW-1] && (dot_r != '0);
    late_nxt.csgn = csgn6_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ldl_r[0] <= late_nxt;
      for (int k = 1; k < LDLY; k++) begin
        ldl_r[k] <= ldl_r[k-1];
      end
    end
  end

  // Output stage.
  tsg_pkg::tsg_late_t  late;
  logic        [NRW:0] nround [3];
  logic signed [CW-1:0] nmag [3];
  logic signed [CW-1:0] nval [3];

  logic        [51:0]   area_r;
  logic signed [CW-1:0] normal_r [3];
  logic signed [CW-1:0] mid_r [3];
  logic        [33:0]   edge_r;
  logic                 deg_r;

  assign late = ldl_r[LDLY-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nround[j] = {1'b0, nroot[j]} + (NRW+1)'(1);
      nmag[j]   = CW'(nround[j][NRW:1]);
      if (late.deg) begin
        nval[j] = '0;
      end else if (late.csgn[j] != late.flip) begin
        nval[j] = -nmag[j];
      end else begin
        nval[j] = nmag[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      area_r <= late.deg ? '0 : 52'(adl_r[ADLY-1]);
      for (int j = 0; j < 3; j++) begin
        normal_r[j] <= nval[j];
        mid_r[j]    <= late.mid[j];
      end
      edge_r <= 34'(edl_r[EDLY-1]);
      deg_r  <= late.deg;
    end
  end

  assign out_area         = area_r;
  assign out_normal_x     = normal_r[0];
  assign out_normal_y     = normal_r[1];
  assign out_normal_z     = normal_r[2];
  assign out_mid_x        = mid_r[0];
  assign out_mid_y        = mid_r[1];
  assign out_mid_z        = mid_r[2];
  assign out_longest_edge = edge_r;
  assign out_degenerate   = deg_r;

endmodule

`default_nettype wire
